### design/gzuf_pkg.sv
package gzuf_pkg;

   localparam int MaxRows = 64;
   localparam int MaxCols = 64;
   localparam int CellCount = MaxRows * MaxCols;
   localparam int IdxW = $clog2(CellCount);
   localparam int CfgW = 7;
   localparam int QueueDepth = 2;

   localparam logic [1:0] AnsInvalid = 2'd3;
   localparam logic [1:0] AnsNeither = 2'd2;

   localparam logic CsrRows = 1'b0;
   localparam logic CsrCols = 1'b1;

   // Job handed from the front part to the back part.
   typedef enum logic [1:0] {
      OP_LOAD,
      OP_QUERY,
      OP_INVALID
   } op_type;

   typedef struct packed {
      op_type          op;
      logic            pix;
      logic [IdxW-1:0] idx_a;
      logic [IdxW-1:0] idx_b;
      logic            has_up;
      logic            has_left;
      logic [6:0]      cols;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_WR,
      ST_FIND_RD,
      ST_FIND_WAIT,
      ST_FIND_STEP,
      ST_COMP_RD,
      ST_COMP_WAIT,
      ST_COMP_STEP,
      ST_NEIGH_RD,
      ST_NEIGH_WAIT,
      ST_UNION,
      ST_BUMP,
      ST_OUT
   } back_state_type;

endpackage

### design/gzuf_front.sv
module gzuf_front import gzuf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write,
   input  logic            csr_index,
   input  logic [CfgW-1:0] csr_data,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_action,
   input  logic            req_pixel_value,
   input  logic [5:0]      req_row_a,
   input  logic [5:0]      req_col_a,
   input  logic [5:0]      req_row_b,
   input  logic [5:0]      req_col_b,
   output logic            job_valid,
   input  logic            job_stall,
   output job_type         job
);

   logic [CfgW-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [IdxW:0]   pos_ff, pos_in;
   logic [5:0]      rc_ff, rc_in;
   logic [5:0]      cc_ff, cc_in;
   logic            done_ff, done_in;
   logic [6:0]      eff_rows, eff_cols;
   logic [IdxW:0]   total;
   logic [IdxW+5:0] prod_a, prod_b;
   logic            acc, oob;

   // Registers clamped into the legal range.
   always_comb begin
      eff_rows = (rows_ff == '0) ? 7'd1 : ((rows_ff > 7'(MaxRows)) ? 7'(MaxRows) : rows_ff);
      eff_cols = (cols_ff == '0) ? 7'd1 : ((cols_ff > 7'(MaxCols)) ? 7'(MaxCols) : cols_ff);
      total    = (IdxW+1)'(eff_rows) * (IdxW+1)'(eff_cols);
      prod_a   = (IdxW+6)'(req_row_a) * (IdxW+6)'(eff_cols) + (IdxW+6)'(req_col_a);
      prod_b   = (IdxW+6)'(req_row_b) * (IdxW+6)'(eff_cols) + (IdxW+6)'(req_col_b);
      oob      = (7'(req_row_a) >= eff_rows) || (7'(req_row_b) >= eff_rows)
              || (7'(req_col_a) >= eff_cols) || (7'(req_col_b) >= eff_cols);
   end

   assign req_stall = job_stall;
   assign acc       = req_valid && !req_stall;

   // Classify the word; loads after completion are dropped here.
   always_comb begin
      job.pix      = req_pixel_value;
      job.cols     = eff_cols;
      job.has_up   = (rc_ff != '0);
      job.has_left = (cc_ff != '0);
      job_valid    = req_valid;
      if (!req_action) begin
         job.op    = OP_LOAD;
         job.idx_a = pos_ff[IdxW-1:0];
         job.idx_b = pos_ff[IdxW-1:0];
         job_valid = req_valid && !done_ff;
      end else begin
         job.op    = (!done_ff || oob) ? OP_INVALID : OP_QUERY;
         job.idx_a = prod_a[IdxW-1:0];
         job.idx_b = prod_b[IdxW-1:0];
      end
   end

   // Load position tracking with row and column counters.
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      pos_in  = pos_ff;
      rc_in   = rc_ff;
      cc_in   = cc_ff;
      done_in = done_ff;
      if (csr_write) begin
         if (csr_index == CsrRows) rows_in = csr_data;
         else                      cols_in = csr_data;
         pos_in  = '0;
         rc_in   = '0;
         cc_in   = '0;
         done_in = 1'b0;
      end else if (acc && !req_action && !done_ff) begin
         pos_in = pos_ff + 1'b1;
         if (7'(cc_ff) + 7'd1 >= eff_cols) begin
            cc_in = '0;
            rc_in = rc_ff + 1'b1;
         end else begin
            cc_in = cc_ff + 1'b1;
         end
         if (pos_ff + 1'b1 >= total) done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 7'(MaxRows);
         cols_ff <= 7'(MaxCols);
         pos_ff  <= '0;
         rc_ff   <= '0;
         cc_ff   <= '0;
         done_ff <= 1'b0;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         pos_ff  <= pos_in;
         rc_ff   <= rc_in;
         cc_ff   <= cc_in;
         done_ff <= done_in;
      end
   end

endmodule

### design/gzuf_queue.sv
module gzuf_queue import gzuf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_stall,
   output job_type out_job
);

   localparam int PtrW = $clog2(QueueDepth);

   job_type         slot_ff [QueueDepth];
   logic [PtrW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PtrW:0]   cnt_ff, cnt_in;
   logic            push, pop;

   assign in_stall  = (cnt_ff == (PtrW+1)'(QueueDepth));
   assign out_valid = (cnt_ff != '0);
   assign out_job   = slot_ff[rp_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   // Pointer and fill count update.
   always_comb begin
      wp_in  = push ? PtrW'(wp_ff + 1'b1) : wp_ff;
      rp_in  = pop  ? PtrW'(rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= in_job;
   end

endmodule

### design/gzuf_back.sv
module gzuf_back import gzuf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   output logic       job_stall,
   input  job_type    job,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_answer
);

   // One memory word per cell: value, rank and parent.
   localparam int WordW = 1 + 4 + IdxW;

   logic [WordW-1:0] mem [CellCount];
   logic [WordW-1:0] rd_ff;
   logic [IdxW-1:0]  rd_addr;
   logic             rd_en;
   logic [IdxW-1:0]  wr_addr;
   logic [WordW-1:0] wr_data;
   logic             wr_en;

   back_state_type   st_ff, st_in;
   job_type          job_ff, job_in;
   logic [IdxW-1:0]  cur_ff, cur_in, root_ff, root_in, ra_ff, ra_in;
   logic [IdxW-1:0]  nb_ff, nb_in;
   logic [3:0]       rka_ff, rka_in, rkb_ff, rkb_in;
   logic             valb_ff, valb_in;
   logic             side_ff, side_in;
   logic             phase_ff, phase_in;
   logic             va_ff, va_in;
   logic [1:0]       ans_ff, ans_in;
   logic             ov_ff, ov_in;

   logic             rd_val;
   logic [3:0]       rd_rank;
   logic [IdxW-1:0]  rd_par;
   logic [IdxW-1:0]  hi_root, lo_root;
   logic [3:0]       hi_rank;
   logic             bump;

   assign rd_val  = rd_ff[WordW-1];
   assign rd_rank = rd_ff[IdxW+3:IdxW];
   assign rd_par  = rd_ff[IdxW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   assign job_stall  = (st_ff != ST_IDLE) || ov_ff;
   assign rsp_valid  = ov_ff;
   assign rsp_answer = ans_ff;

   // Next state.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:       if (job_valid && !ov_ff) begin
                           unique case (job.op)
                              OP_LOAD:  st_in = ST_LOAD_WR;
                              OP_QUERY: st_in = ST_FIND_RD;
                              default:  st_in = ST_OUT;
                           endcase
                        end
         ST_LOAD_WR:    st_in = (job_ff.has_up || job_ff.has_left) ? ST_NEIGH_RD : ST_IDLE;
         ST_FIND_RD:    st_in = ST_FIND_WAIT;
         ST_FIND_WAIT:  st_in = ST_FIND_STEP;
         ST_FIND_STEP:  st_in = (rd_par == root_ff) ? ST_COMP_RD : ST_FIND_RD;
         ST_COMP_RD:    st_in = ST_COMP_WAIT;
         ST_COMP_WAIT:  st_in = ST_COMP_STEP;
         ST_COMP_STEP:  begin
                           if (rd_par != root_ff) st_in = ST_COMP_RD;
                           else if (!phase_ff) st_in = ST_FIND_RD;
                           else if (job_ff.op == OP_QUERY) st_in = ST_OUT;
                           else st_in = ST_UNION;
                        end
         ST_NEIGH_RD:   st_in = ST_NEIGH_WAIT;
         ST_NEIGH_WAIT: begin
                           if (rd_val == job_ff.pix) st_in = ST_FIND_RD;
                           else if (!side_ff && job_ff.has_left) st_in = ST_NEIGH_RD;
                           else st_in = ST_IDLE;
                        end
         ST_UNION:      begin
                           if (bump) st_in = ST_BUMP;
                           else if (!side_ff && job_ff.has_left) st_in = ST_NEIGH_RD;
                           else st_in = ST_IDLE;
                        end
         ST_BUMP:       begin
                           if (!side_ff && job_ff.has_left) st_in = ST_NEIGH_RD;
                           else st_in = ST_IDLE;
                        end
         ST_OUT:        st_in = ST_IDLE;
         default:       st_in = ST_IDLE;
      endcase
   end

   // Union by rank: the higher ranked root wins, ties go to the first root.
   always_comb begin
      if (rka_ff < rkb_ff) begin
         hi_root = root_ff;
         lo_root = ra_ff;
         hi_rank = rkb_ff;
      end else begin
         hi_root = ra_ff;
         lo_root = root_ff;
         hi_rank = rka_ff;
      end
      bump = (ra_ff != root_ff) && (rka_ff == rkb_ff) && (rka_ff < 4'd15);
   end

   // Datapath and memory controls.
   always_comb begin
      job_in   = job_ff;
      cur_in   = cur_ff;
      root_in  = root_ff;
      ra_in    = ra_ff;
      nb_in    = nb_ff;
      rka_in   = rka_ff;
      rkb_in   = rkb_ff;
      valb_in  = valb_ff;
      side_in  = side_ff;
      phase_in = phase_ff;
      va_in    = va_ff;
      ans_in   = ans_ff;
      ov_in    = ov_ff && rsp_stall;
      rd_en    = 1'b0;
      rd_addr  = root_ff;
      wr_en    = 1'b0;
      wr_addr  = cur_ff;
      wr_data  = rd_ff;
      unique case (st_ff)
         ST_IDLE: if (job_valid && !ov_ff) begin
            job_in   = job;
            cur_in   = job.idx_a;
            root_in  = job.idx_a;
            phase_in = 1'b0;
            side_in  = job.has_up ? 1'b0 : 1'b1;
            ans_in   = AnsInvalid;
         end
         ST_LOAD_WR: begin
            wr_en   = 1'b1;
            wr_addr = job_ff.idx_a;
            wr_data = {job_ff.pix, 4'd0, job_ff.idx_a};
         end
         ST_NEIGH_RD: begin
            nb_in   = side_ff ? IdxW'(job_ff.idx_a - 1'b1)
                              : IdxW'(job_ff.idx_a - IdxW'(job_ff.cols));
            rd_en   = 1'b1;
            rd_addr = nb_in;
            phase_in = 1'b0;
            cur_in   = job_ff.idx_a;
            root_in  = job_ff.idx_a;
         end
         // A neighbor of the other value is skipped.
         ST_NEIGH_WAIT: if (rd_val != job_ff.pix) side_in = 1'b1;
         ST_FIND_RD: begin
            rd_en   = 1'b1;
            rd_addr = root_ff;
         end
         ST_FIND_WAIT: ;
         ST_FIND_STEP: begin
            if (rd_par != root_ff) root_in = rd_par;
            else if (!phase_ff) begin
               ra_in  = root_ff;
               rka_in = rd_rank;
               va_in  = rd_val;
            end else begin
               rkb_in  = rd_rank;
               valb_in = rd_val;
            end
         end
         ST_COMP_RD: begin
            rd_en   = 1'b1;
            rd_addr = cur_ff;
         end
         ST_COMP_WAIT: ;
         ST_COMP_STEP: begin
            if (rd_par != root_ff) begin
               wr_en   = 1'b1;
               wr_addr = cur_ff;
               wr_data = {rd_val, rd_rank, root_ff};
               cur_in  = rd_par;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
               if (job_ff.op == OP_QUERY) begin
                  cur_in  = job_ff.idx_b;
                  root_in = job_ff.idx_b;
               end else begin
                  cur_in  = nb_ff;
                  root_in = nb_ff;
               end
            end else if (job_ff.op == OP_QUERY) begin
               ans_in = (ra_ff == root_ff) ? {1'b0, va_ff} : AnsNeither;
            end
         end
         ST_UNION: begin
            if (ra_ff != root_ff) begin
               wr_en   = 1'b1;
               wr_addr = lo_root;
               wr_data = {(rka_ff < rkb_ff) ? va_ff : valb_ff,
                          (rka_ff < rkb_ff) ? rka_ff : rkb_ff, hi_root};
            end
            if (!bump) side_in = 1'b1;
         end
         // On a rank tie below 15 the winning root gets its rank raised by one.
         ST_BUMP: begin
            wr_en   = 1'b1;
            wr_addr = hi_root;
            wr_data = {va_ff, 4'(hi_rank + 4'd1), hi_root};
            side_in = 1'b1;
         end
         ST_OUT: ov_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      cur_ff   <= cur_in;
      root_ff  <= root_in;
      ra_ff    <= ra_in;
      nb_ff    <= nb_in;
      rka_ff   <= rka_in;
      rkb_ff   <= rkb_in;
      valb_ff  <= valb_in;
      side_ff  <= side_in;
      phase_ff <= phase_in;
      va_ff    <= va_in;
      ans_ff   <= ans_in;
   end

endmodule

### design/grid_zone_union_find_top.sv
// Channel | Direction | Ports
// req     | in        | req_valid, req_stall, req_action .. req_col_b
// rsp     | out       | rsp_valid, rsp_stall, rsp_answer
// csr     | in        | csr_write, csr_index, csr_data
//
// A word passes through a registered queue; a load then writes its cell, reads each
// neighbor, skips one of the other value, and for a matching one runs two finds with
// path compression, joins the roots and, on a rank tie, raises the winner's rank.
// A valid query runs two finds, an invalid one goes straight to its answer; the
// answer is registered and then offered. Reset is synchronous and clears control state.
// The back holds off new words while an answer waits; the input stalls when full.
module grid_zone_union_find_top import gzuf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write,
   input  logic            csr_index,
   input  logic [CfgW-1:0] csr_data,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_action,
   input  logic            req_pixel_value,
   input  logic [5:0]      req_row_a,
   input  logic [5:0]      req_col_a,
   input  logic [5:0]      req_row_b,
   input  logic [5:0]      req_col_b,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [1:0]      rsp_answer
);

   logic    fj_valid, fj_stall, bj_valid, bj_stall;
   job_type fj, bj;

   gzuf_front u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_valid, .req_stall, .req_action, .req_pixel_value,
      .req_row_a, .req_col_a, .req_row_b, .req_col_b,
      .job_valid(fj_valid), .job_stall(fj_stall), .job(fj)
   );

   gzuf_queue u_queue (
      .clock, .reset,
      .in_valid(fj_valid), .in_stall(fj_stall), .in_job(fj),
      .out_valid(bj_valid), .out_stall(bj_stall), .out_job(bj)
   );

   gzuf_back u_back (
      .clock, .reset,
      .job_valid(bj_valid), .job_stall(bj_stall), .job(bj),
      .rsp_valid, .rsp_stall, .rsp_answer
   );

`ifndef SYNTH
   // A held response keeps its answer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_answer))
      else $error("response dropped or changed while stalled");

   // The back never takes a job while a response is pending.
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> bj_stall)
      else $error("job taken with response pending");
`endif

endmodule

### test/grid_zone_union_find_top_test.sv
module grid_zone_union_find_top_test;
   import gzuf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Zone answer scoreboard: keeps its own copy of the map and union-find forest.
   class zone_board;
      int unsigned rows_reg, cols_reg;
      bit          cell_val [CellCount];
      int unsigned link [CellCount];
      int unsigned rank [CellCount];
      int unsigned load_pos;
      bit          complete;
      logic [1:0]  answers [$];
      int          errors, checked, queries, loads;

      function void clear();
         rows_reg = 64;
         cols_reg = 64;
         foreach (cell_val[i]) begin
            cell_val[i] = 0;
            link[i] = 0;
            rank[i] = 0;
         end
         load_pos = 0;
         complete = 0;
      endfunction

      function int unsigned eff(int unsigned v);
         if (v == 0) return 1;
         return v > 64 ? 64 : v;
      endfunction

      function void write_reg(logic idx, logic [CfgW-1:0] val);
         if (idx == CsrRows) rows_reg = val;
         else cols_reg = val;
         load_pos = 0;
         complete = 0;
      endfunction

      function int unsigned root_of(int unsigned node);
         int unsigned r, cur, nxt;
         r = node;
         cur = node;
         while (link[r] != r) r = link[r];
         while (cur != r) begin
            nxt = link[cur];
            link[cur] = r;
            cur = nxt;
         end
         return r;
      endfunction

      function void merge(int unsigned a, int unsigned b);
         int unsigned ra, rb, t;
         ra = root_of(a);
         rb = root_of(b);
         if (ra == rb) return;
         if (rank[ra] < rank[rb]) begin
            t = ra;
            ra = rb;
            rb = t;
         end
         link[rb] = ra;
         if (rank[ra] == rank[rb] && rank[ra] < 15) rank[ra]++;
      endfunction

      // Note an accepted word and queue its expected answer, if any.
      function void note_word(logic act, logic pix, logic [5:0] ra, logic [5:0] ca,
                              logic [5:0] rb, logic [5:0] cb);
         int unsigned nr, nc, p, ia, ib;
         nr = eff(rows_reg);
         nc = eff(cols_reg);
         if (act == 1'b0) begin
            if (complete) return;
            loads++;
            p = load_pos;
            cell_val[p] = pix;
            link[p] = p;
            rank[p] = 0;
            if (p / nc > 0 && cell_val[p - nc] == pix) merge(p, p - nc);
            if (p % nc > 0 && cell_val[p - 1] == pix) merge(p, p - 1);
            load_pos = p + 1;
            if (load_pos >= nr * nc) complete = 1;
            return;
         end
         queries++;
         if (!complete || ra >= nr || rb >= nr || ca >= nc || cb >= nc) begin
            answers.push_back(AnsInvalid);
            return;
         end
         ia = ra * nc + ca;
         ib = rb * nc + cb;
         if (root_of(ia) == root_of(ib)) answers.push_back({1'b0, cell_val[ia]});
         else answers.push_back(AnsNeither);
      endfunction

      function void check_answer(logic [1:0] got);
         logic [1:0] want;
         checked++;
         if (answers.size() == 0) begin
            $error("answer %0d arrived with nothing expected", got);
            errors++;
            return;
         end
         want = answers.pop_front();
         if (got !== want) begin
            $error("answer: expected %0d, actual %0d", want, got);
            errors++;
         end
      endfunction
   endclass

   logic            clock = 0;
   logic            reset = 1;
   logic            csr_write = 0;
   logic            csr_index = 0;
   logic [CfgW-1:0] csr_data = '0;
   logic            req_valid = 0;
   logic            req_stall;
   logic            req_action = 0;
   logic            req_pixel_value = 0;
   logic [5:0]      req_row_a = '0, req_col_a = '0, req_row_b = '0, req_col_b = '0;
   logic            rsp_valid;
   logic            rsp_stall = 0;
   logic [1:0]      rsp_answer;

   zone_board board = new();
   bit sender_gaps = 1;
   bit receiver_gaps = 1;
   bit long_hold = 0;

   grid_zone_union_find_top dut (.*);

   always #1 clock = ~clock;

   // Receiver: random stall bursts, optional long hold-off, answer checking.
   initial begin
      int burst;
      burst = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) board.check_answer(rsp_answer);
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (300) @(posedge clock);
            long_hold = 0;
            rsp_stall <= 0;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= (burst > 0);
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 17);
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // Offer one word and hold it until accepted, sometimes after a random gap first.
   // Valid stays high after acceptance; the next word or an idle phase follows.
   task automatic send_word(logic act, logic pix, logic [5:0] ra, logic [5:0] ca,
                            logic [5:0] rb, logic [5:0] cb);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1;
      req_action <= act;
      req_pixel_value <= pix;
      req_row_a <= ra;
      req_col_a <= ca;
      req_row_b <= rb;
      req_col_b <= cb;
      do @(posedge clock); while (req_stall);
      board.note_word(act, pix, ra, ca, rb, cb);
   endtask

   task automatic load_pixel(int pix);
      send_word(1'b0, 1'(pix), '0, '0, '0, '0);
   endtask

   task automatic ask(int ra, int ca, int rb, int cb);
      send_word(1'b1, 1'b0, 6'(ra), 6'(ca), 6'(rb), 6'(cb));
   endtask

   // Drain all answers and let the last load finish before touching registers.
   task automatic settle();
      req_valid <= 0;
      while (board.answers.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CfgW-1:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      board.write_reg(idx, val);
   endtask

   task automatic configure(int nr, int nc);
      settle();
      write_csr(CsrRows, 7'(nr));
      write_csr(CsrCols, 7'(nc));
      csr_write <= 0;
   endtask

   // Load a full map; mode 0 random, 1 stripes, 2 checkerboard-ish blobs.
   task automatic load_map(int mode);
      int unsigned nr, nc;
      nr = board.eff(board.rows_reg);
      nc = board.eff(board.cols_reg);
      for (int i = 0; i < nr * nc; i++) begin
         case (mode)
            0: load_pixel($urandom_range(0, 1));
            1: load_pixel((i / nc) % 2);
            default: load_pixel(((i / nc) / 2 + (i % nc) / 2) % 2 ^ ($urandom_range(0, 7) == 0));
         endcase
      end
   endtask

   // Random query, mostly in range, sometimes deliberately out of range.
   task automatic random_query();
      int unsigned nr, nc;
      nr = board.eff(board.rows_reg);
      nc = board.eff(board.cols_reg);
      if ($urandom_range(0, 9) == 0)
         ask($urandom, $urandom, $urandom, $urandom);
      else
         ask($urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
             $urandom_range(0, nr - 1), $urandom_range(0, nc - 1));
   endtask

   initial begin
      int items;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: query before complete, small map, extremes, loads after complete.
      configure(2, 3);
      ask(0, 0, 0, 0);
      load_pixel(1); load_pixel(0); load_pixel(1);
      load_pixel(1); load_pixel(1); load_pixel(0);
      load_pixel(0);
      ask(0, 0, 1, 1);
      ask(0, 1, 1, 2);
      ask(0, 1, 0, 0);
      ask(1, 0, 0, 2);
      ask(2, 0, 0, 0);
      ask(0, 3, 0, 0);
      ask(63, 63, 63, 63);
      configure(0, 127);
      load_map(0);
      ask(0, 0, 0, 63);
      ask(0, 63, 0, 0);
      configure(1, 1);
      load_pixel(0);
      ask(0, 0, 0, 0);

      // Random phases over several sizes, the tallest map among them.
      items = 0;
      for (int ph = 0; items < 850 && ph < 40; ph++) begin
         if (ph == 6) configure(64, 4);
         else if (ph == 7) configure(100, 0);
         else configure($urandom_range(1, 8), $urandom_range(1, 8));
         if ($urandom_range(0, 3) == 0) random_query();
         load_map(ph % 3);
         items += board.eff(board.rows_reg) * board.eff(board.cols_reg);
         if (ph == 3) long_hold = 1;
         if (ph >= 10) begin
            sender_gaps = 0;
            receiver_gaps = 0;
         end
         for (int q = 0; q < 20; q++) begin
            if ($urandom_range(0, 9) == 0) load_pixel($urandom_range(0, 1));
            else random_query();
            items++;
         end
      end

      req_valid <= 0;
      while (board.answers.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Checked %0d answers from %0d queries over %0d loaded pixels.",
               board.checked, board.queries, board.loads);
      if (board.errors == 0 && board.answers.size() == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      board.clear();
      #4000000;
      $display("simulation failed");
      $finish;
   end
endmodule
